// ----- hdl/ata_pkg.sv -----
// Shared types, widths and constants for the accelerometer tilt angle pipeline.
package ata_pkg;

	localparam int AX_W = 16;
	localparam int PITCH_W = 15;
	localparam int ROLL_W = 16;
	localparam int HEAD_W = 16;

	localparam int CORDIC_STAGES = 16;
	localparam int ANGLE_FRAC_BITS = 7;

	localparam int ACC_FRAC = 20;
	localparam int TABLE_LEN = 24;
	localparam int STG_W = $clog2(TABLE_LEN);
	localparam int MAG_FRAC = 8;

	localparam int PROD_W = 2 * AX_W;
	localparam int SUM_W = PROD_W;
	localparam int RAD_W = SUM_W + 2 * MAG_FRAC;
	localparam int SQ_W = RAD_W / 2;
	localparam int SQ_STEPS = SQ_W;
	localparam int REM_W = SQ_W + 3;

	localparam int ARG_W = SQ_W + 1;
	localparam int X_W = ARG_W + MAG_FRAC + 3;
	localparam int Z_W = 31;
	localparam int ROUND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int ANG_W = Z_W - ROUND_SH + 1;
	localparam int LIMD_W = 8;

	localparam int DLY = 2 + SQ_STEPS;
	localparam int PIPE_LAT = DLY + 1 + CORDIC_STAGES + 3;

	localparam logic signed [Z_W-1:0] Z_DEG90 = Z_W'(90 * (1 << ACC_FRAC));
	localparam logic signed [Z_W-1:0] Z_DEG180 = Z_W'(180 * (1 << ACC_FRAC));
	localparam logic [Z_W-1:0] RND_HALF = Z_W'(1) << (ROUND_SH - 1);

	localparam logic [LIMD_W-1:0] PITCH_LIM_DEG = LIMD_W'(90);
	localparam logic [LIMD_W-1:0] FULL_LIM_DEG = LIMD_W'(180);
	localparam int PITCH_LIM = 90 * (1 << ANGLE_FRAC_BITS);
	localparam int FULL_LIM = 180 * (1 << ANGLE_FRAC_BITS);

	typedef struct packed {
		logic signed [AX_W-1:0] accel_x;
		logic signed [AX_W-1:0] accel_y;
		logic signed [AX_W-1:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch_angle;
		logic signed [ROLL_W-1:0] roll_angle;
		logic signed [HEAD_W-1:0] heading_angle;
	} angles_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic run;
		logic signed [X_W-1:0] x;
		logic signed [X_W-1:0] y;
		logic signed [Z_W-1:0] z;
	} cordic_t;

	function automatic logic signed [Z_W-1:0] atan_val(input logic [STG_W-1:0] idx);
		case (idx)
			0: atan_val = Z_W'(47185920);
			1: atan_val = Z_W'(27855475);
			2: atan_val = Z_W'(14718068);
			3: atan_val = Z_W'(7471121);
			4: atan_val = Z_W'(3750058);
			5: atan_val = Z_W'(1876857);
			6: atan_val = Z_W'(938658);
			7: atan_val = Z_W'(469357);
			8: atan_val = Z_W'(234682);
			9: atan_val = Z_W'(117342);
			10: atan_val = Z_W'(58671);
			11: atan_val = Z_W'(29335);
			12: atan_val = Z_W'(14668);
			13: atan_val = Z_W'(7334);
			14: atan_val = Z_W'(3667);
			15: atan_val = Z_W'(1833);
			16: atan_val = Z_W'(917);
			17: atan_val = Z_W'(458);
			18: atan_val = Z_W'(229);
			19: atan_val = Z_W'(115);
			20: atan_val = Z_W'(57);
			21: atan_val = Z_W'(29);
			22: atan_val = Z_W'(14);
			23: atan_val = Z_W'(7);
			default: atan_val = '0;
		endcase
	endfunction

endpackage

// ----- hdl/ata_sqrt_cell.sv -----
// One radix-2 step (two radicand bits in, one root bit out) of the pipelined integer square root.
module ata_sqrt_cell import ata_pkg::*; (
	input logic clk,
	input logic en,
	input sqrt_t din,
	output sqrt_t dout
);

	logic [REM_W-1:0] cur;
	logic [REM_W-1:0] trial;
	logic ge;
	sqrt_t nxt;
	sqrt_t cell_q;

	always_comb begin
		cur = {din.rem[REM_W-3:0], din.rad[RAD_W-1 -: 2]};
		trial = REM_W'({din.root, 2'b01});
		ge = (cur >= trial);
		nxt.rad = din.rad << 2;
		nxt.rem = ge ? cur - trial : cur;
		nxt.root = {din.root[SQ_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule

// ----- hdl/ata_cordic_cell.sv -----
// One vectoring rotation of the CORDIC arctangent chain.
module ata_cordic_cell import ata_pkg::*; (
	input logic clk,
	input logic en,
	input logic [STG_W-1:0] stage,
	input cordic_t din,
	output cordic_t dout
);

	logic signed [X_W-1:0] xi;
	logic signed [X_W-1:0] yi;
	logic signed [Z_W-1:0] zi;
	logic signed [X_W-1:0] dx;
	logic signed [X_W-1:0] dy;
	logic signed [Z_W-1:0] ang;
	logic pos;
	cordic_t nxt;
	cordic_t cell_q;

	always_comb begin
		xi = din.x;
		yi = din.y;
		zi = din.z;
		dx = yi >>> stage;
		dy = xi >>> stage;
		ang = atan_val(stage);
		pos = !yi[X_W-1] && (yi != '0);
		nxt = din;
		if (din.run) begin
			if (pos) begin
				nxt.x = xi + dx;
				nxt.y = yi - dy;
				nxt.z = zi + ang;
			end else begin
				nxt.x = xi - dx;
				nxt.y = yi + dy;
				nxt.z = zi - ang;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dout = cell_q;

endmodule

// ----- hdl/ata_atan2.sv -----
// Pipelined atan2 in degrees: special cases, CORDIC cell chain, rounding and clamping.
module ata_atan2 import ata_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [ARG_W-1:0] num,
	input logic signed [ARG_W-1:0] den,
	input logic [LIMD_W-1:0] lim_deg,
	output logic signed [ANG_W-1:0] angle
);

	logic num_zero;
	logic den_zero;
	logic den_neg;
	logic num_pos;
	logic signed [ARG_W-1:0] num_a;
	logic signed [ARG_W-1:0] den_a;
	cordic_t prep;
	cordic_t prep_s1;
	cordic_t chain [CORDIC_STAGES+1];

	logic signed [Z_W-1:0] zf;
	logic neg_a_q;
	logic [Z_W-1:0] mag_q;
	logic [Z_W-1:0] rsum;
	logic [ANG_W-1:0] rnd;
	logic [ANG_W-1:0] lim;
	logic neg_b_q;
	logic [ANG_W-1:0] res_q;
	logic signed [ANG_W-1:0] angle_q;

	always_comb begin
		num_zero = (num == '0);
		den_zero = (den == '0);
		den_neg = den[ARG_W-1];
		num_pos = !num[ARG_W-1] && !num_zero;
		num_a = den_neg ? -num : num;
		den_a = den_neg ? -den : den;
		prep.run = 1'b0;
		prep.x = X_W'(den_a) <<< MAG_FRAC;
		prep.y = X_W'(num_a) <<< MAG_FRAC;
		prep.z = '0;
		if (num_zero) begin
			if (den_neg) begin
				prep.z = Z_DEG180;
			end
		end else if (den_zero) begin
			prep.z = num_pos ? Z_DEG90 : -Z_DEG90;
		end else begin
			prep.run = 1'b1;
			if (den_neg) begin
				prep.z = num_pos ? Z_DEG180 : -Z_DEG180;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= prep;
		end
	end

	assign chain[0] = prep_s1;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		ata_cordic_cell u_cell (
			.clk(clk),
			.en(en),
			.stage(STG_W'(i)),
			.din(chain[i]),
			.dout(chain[i+1])
		);
	end

	assign zf = chain[CORDIC_STAGES].z;

	always_comb begin
		rsum = mag_q + RND_HALF;
		rnd = ANG_W'(rsum >> ROUND_SH);
		lim = ANG_W'(lim_deg) << ANGLE_FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_a_q <= zf[Z_W-1];
			mag_q <= zf[Z_W-1] ? Z_W'(-zf) : Z_W'(zf);
			neg_b_q <= neg_a_q;
			res_q <= (rnd > lim) ? lim : rnd;
			angle_q <= neg_b_q ? ANG_W'(-$signed(res_q)) : $signed(res_q);
		end
	end

	assign angle = angle_q;

endmodule

// ----- hdl/accel_tilt_angles.sv -----
// Top level: pitch, roll and heading from one accelerometer sample per cycle while sample_stall is low.
//
//   channel  direction  handshake                    payload
//   sample   in         sample_valid / sample_stall  sample (accel_x, accel_y, accel_z)
//   angles   out        angles_valid / angles_stall  angles (pitch, roll, heading)
//
// One transaction is accepted per cycle while sample_stall is low.
// The pipeline is made of the squaring and sum stages, 24 square root cells,
// the CORDIC prep stage, 16 CORDIC cells, three rounding stages and the output register.
// Reset clears only the valid bits; no state is carried between samples.
// sample_stall rises only when the output register holds a stalled result and
// the last pipeline stage also holds one.
module accel_tilt_angles import ata_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input sample_t sample,
	output logic angles_valid,
	input logic angles_stall,
	output angles_t angles
);

	logic adv;
	logic out_ld;
	logic [PIPE_LAT-1:0] vld_q;
	logic out_vld_q;
	angles_t angles_q;

	logic signed [AX_W-1:0] ay_in;
	logic signed [AX_W-1:0] az_in;
	logic signed [PROD_W-1:0] sq_y_s1;
	logic signed [PROD_W-1:0] sq_z_s1;
	logic [SUM_W-1:0] sum_s2;
	sqrt_t sq_chain [SQ_STEPS+1];
	sample_t dly_q [DLY];

	logic signed [AX_W-1:0] dx;
	logic signed [AX_W-1:0] dy;
	logic signed [AX_W-1:0] dz;
	logic signed [ARG_W-1:0] p_num;
	logic signed [ARG_W-1:0] p_den;
	logic signed [ANG_W-1:0] pitch_ang;
	logic signed [ANG_W-1:0] roll_ang;
	logic signed [ANG_W-1:0] head_ang;

	assign out_ld = !out_vld_q || !angles_stall;
	assign adv = out_ld || !vld_q[PIPE_LAT-1];
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[PIPE_LAT-2:0], sample_valid};
			end
			if (out_ld) begin
				out_vld_q <= vld_q[PIPE_LAT-1];
			end
		end
	end

	assign ay_in = sample.accel_y;
	assign az_in = sample.accel_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_y_s1 <= ay_in * ay_in;
			sq_z_s1 <= az_in * az_in;
			sum_s2 <= SUM_W'(sq_y_s1[PROD_W-2:0]) + SUM_W'(sq_z_s1[PROD_W-2:0]);
			dly_q[0] <= sample;
			for (int k = 1; k < DLY; k++) begin
				dly_q[k] <= dly_q[k-1];
			end
		end
	end

	assign sq_chain[0].rad = {sum_s2, {(2 * MAG_FRAC){1'b0}}};
	assign sq_chain[0].rem = '0;
	assign sq_chain[0].root = '0;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		ata_sqrt_cell u_sqrt_cell (
			.clk(clk),
			.en(adv),
			.din(sq_chain[i]),
			.dout(sq_chain[i+1])
		);
	end

	assign dx = dly_q[DLY-1].accel_x;
	assign dy = dly_q[DLY-1].accel_y;
	assign dz = dly_q[DLY-1].accel_z;
	assign p_num = -(ARG_W'(dx) <<< MAG_FRAC);
	assign p_den = ARG_W'(sq_chain[SQ_STEPS].root);

	ata_atan2 u_pitch (
		.clk(clk),
		.en(adv),
		.num(p_num),
		.den(p_den),
		.lim_deg(PITCH_LIM_DEG),
		.angle(pitch_ang)
	);

	ata_atan2 u_roll (
		.clk(clk),
		.en(adv),
		.num(ARG_W'(dy)),
		.den(ARG_W'(dz)),
		.lim_deg(FULL_LIM_DEG),
		.angle(roll_ang)
	);

	ata_atan2 u_heading (
		.clk(clk),
		.en(adv),
		.num(ARG_W'(dx)),
		.den(ARG_W'(dy)),
		.lim_deg(FULL_LIM_DEG),
		.angle(head_ang)
	);

	always_ff @(posedge clk) begin
		if (out_ld) begin
			angles_q.pitch_angle <= PITCH_W'(pitch_ang);
			angles_q.roll_angle <= ROLL_W'(roll_ang);
			angles_q.heading_angle <= HEAD_W'(head_ang);
		end
	end

	assign angles_valid = out_vld_q;
	assign angles = angles_q;

endmodule

// ----- hdl/ata_checker.sv -----
// Port-level checks for the tilt angle block and the bind that attaches them.
module ata_checker import ata_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic sample_stall,
	input logic angles_valid,
	input logic angles_stall,
	input angles_t angles
);

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!angles_valid |-> !sample_stall)
		else $error("input stalled while no result is waiting");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && angles_stall |=> angles_valid && $stable(angles))
		else $error("stalled result transaction changed or vanished");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid |-> (angles.pitch_angle <= PITCH_LIM) &&
			(angles.pitch_angle >= -PITCH_LIM))
		else $error("pitch outside of +-90 degrees");

	a_full_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid |-> (angles.roll_angle <= FULL_LIM) &&
			(angles.roll_angle >= -FULL_LIM) &&
			(angles.heading_angle <= FULL_LIM) &&
			(angles.heading_angle >= -FULL_LIM))
		else $error("roll or heading outside of +-180 degrees");

endmodule

bind accel_tilt_angles ata_checker u_ata_checker (.*);

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the accelerometer tilt angle pipeline.
module testbench;
	import ata_pkg::*;

	localparam longint ATAN_DEG[TABLE_LEN] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sample_t sample = '0;
	logic angles_valid;
	logic angles_stall = 1'b0;
	angles_t angles;

	angles_t angles_due[$];
	int err_count = 0;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	int recv_hold = 0;

	accel_tilt_angles uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.angles_valid(angles_valid),
		.angles_stall(angles_stall),
		.angles(angles)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned radicand);
		longint unsigned rest;
		longint unsigned root;
		longint unsigned probe;
		rest = radicand;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe >>= 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	function automatic longint cordic_angle(input longint num, input longint den,
			input longint lim_deg);
		longint yy;
		longint xx;
		longint acc;
		longint dx;
		longint dy;
		longint lim;
		int sh;
		int i;
		yy = num;
		xx = den;
		sh = ACC_FRAC - ANGLE_FRAC_BITS;
		if (yy == 0 && xx >= 0) begin
			acc = 0;
		end else if (yy == 0) begin
			acc = longint'(180) << ACC_FRAC;
		end else if (xx == 0) begin
			acc = (yy > 0) ? (longint'(90) << ACC_FRAC) : -(longint'(90) << ACC_FRAC);
		end else begin
			acc = 0;
			if (xx < 0) begin
				acc = (yy > 0) ? (longint'(180) << ACC_FRAC) : -(longint'(180) << ACC_FRAC);
				xx = -xx;
				yy = -yy;
			end
			xx = xx * 256;
			yy = yy * 256;
			for (i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
				dx = yy >>> i;
				dy = xx >>> i;
				if (yy > 0) begin
					xx += dx;
					yy -= dy;
					acc += ATAN_DEG[i];
				end else begin
					xx -= dx;
					yy += dy;
					acc -= ATAN_DEG[i];
				end
			end
		end
		if (acc >= 0)
			acc = (acc + (longint'(1) << (sh - 1))) >>> sh;
		else
			acc = -((-acc + (longint'(1) << (sh - 1))) >>> sh);
		lim = lim_deg * (longint'(1) << ANGLE_FRAC_BITS);
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		return acc;
	endfunction

	function automatic angles_t tilt_angles_of(input sample_t s);
		longint ax;
		longint ay;
		longint az;
		longint mag;
		angles_t a;
		ax = $signed(s.accel_x);
		ay = $signed(s.accel_y);
		az = $signed(s.accel_z);
		mag = longint'(int_sqrt(longint'(ay * ay + az * az) << 16));
		a.pitch_angle = PITCH_W'(cordic_angle(-ax * 256, mag, 90));
		a.roll_angle = ROLL_W'(cordic_angle(ay, az, 180));
		a.heading_angle = HEAD_W'(cordic_angle(ax, ay, 180));
		return a;
	endfunction

	function automatic logic [AX_W-1:0] draw_axis();
		case ($urandom_range(0, 9))
			0: return AX_W'($urandom_range(0, 8) - 4);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h8001;
					2: return 16'h7FFF;
					default: return '0;
				endcase
			end
			default: return AX_W'($urandom);
		endcase
	endfunction

	function automatic sample_t draw_sample();
		sample_t s;
		s.accel_x = draw_axis();
		s.accel_y = draw_axis();
		s.accel_z = draw_axis();
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("Mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic send_sample(input sample_t s);
		int gap;
		gap = send_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		angles_due.push_back(tilt_angles_of(s));
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (angles_due.size() != 0)
			@(posedge clk);
	endtask

	// Results are checked against the oldest expected angles on every accepted transaction.
	always @(posedge clk) begin
		angles_t want;
		if (angles_valid && !angles_stall) begin
			if (angles_due.size() == 0) begin
				report_mismatch("result transaction with no sample outstanding");
			end else begin
				want = angles_due.pop_front();
				if (angles.pitch_angle !== want.pitch_angle)
					report_mismatch($sformatf("pitch_angle got %0d expected %0d",
						$signed(angles.pitch_angle), $signed(want.pitch_angle)));
				if (angles.roll_angle !== want.roll_angle)
					report_mismatch($sformatf("roll_angle got %0d expected %0d",
						$signed(angles.roll_angle), $signed(want.roll_angle)));
				if (angles.heading_angle !== want.heading_angle)
					report_mismatch($sformatf("heading_angle got %0d expected %0d",
						$signed(angles.heading_angle), $signed(want.heading_angle)));
			end
			recv_hold = recv_idle ? $urandom_range(0, 10) : 0;
		end
		if (recv_hold > 0) begin
			angles_stall <= 1'b1;
			recv_hold--;
		end else begin
			angles_stall <= 1'b0;
		end
	end

	task automatic test_corner_cases();
		int corner_set[22][3] = '{
			'{0, 0, 0}, '{32767, 0, 0}, '{-32768, 0, 0}, '{0, 32767, 0},
			'{0, -32768, 0}, '{0, 0, 32767}, '{0, 0, -32768},
			'{32767, 32767, 32767}, '{-32768, -32768, -32768}, '{1, 1, 1},
			'{-1, -1, -1}, '{5, 0, -7}, '{-5, 0, 7}, '{0, 9, 0}, '{0, -9, 0},
			'{3, -4, -4}, '{-3, 4, -4}, '{-32768, 1, 0}, '{32767, -32768, 32767},
			'{-32768, 32767, -32768}, '{100, -100, -1}, '{12345, -23456, -31000}
		};
		sample_t s;
		send_idle = 1'b0;
		recv_idle <= 1'b0;
		foreach (corner_set[i]) begin
			s.accel_x = AX_W'(corner_set[i][0]);
			s.accel_y = AX_W'(corner_set[i][1]);
			s.accel_z = AX_W'(corner_set[i][2]);
			send_sample(s);
		end
	endtask

	task automatic test_random_samples();
		for (int n = 0; n < 1500; n++) begin
			if (n % 100 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle <= ($urandom_range(0, 3) != 0);
			end
			send_sample(draw_sample());
		end
	endtask

	task automatic test_drain_pauses();
		send_idle = 1'b1;
		recv_idle <= 1'b1;
		for (int n = 0; n < 4; n++) begin
			repeat ($urandom_range(1, 60)) send_sample(draw_sample());
			wait_drained();
		end
	endtask

	task automatic test_output_stall();
		send_idle = 1'b0;
		recv_idle <= 1'b1;
		repeat (300) send_sample(draw_sample());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_random_samples();
		test_drain_pauses();
		test_output_stall();
		wait_drained();
		repeat (PIPE_LAT + 8) @(posedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d results outstanding", angles_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- accel_tilt_angles.f -----
hdl/ata_pkg.sv
hdl/ata_sqrt_cell.sv
hdl/ata_cordic_cell.sv
hdl/ata_atan2.sv
hdl/accel_tilt_angles.sv
hdl/ata_checker.sv
sim/testbench.sv
